### sv/spt_pkg.sv
// Shared types and codes for the sorted priority task list.
`default_nettype none
package spt_pkg;

   // Default sizing
   localparam int DEFAULT_LIST_DEPTH    = 16;
   localparam int DEFAULT_PRIORITY_BITS = 16;

   // Fixed field widths of the request and response beats
   localparam int TAG_BITS      = 16;
   localparam int POS_BITS      = 5;
   localparam int OUT_PRIO_BITS = 16;
   localparam int OUT_CNT_BITS  = 5;

   // Request codes
   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_DELETE = 2'd1,
      REQ_EDIT   = 2'd2,
      REQ_NONE   = 2'd3
   } req_code_type;

   // Response status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_RANGE = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   // Command broadcast to every cell of the chain
   typedef struct packed {
      logic place;   // insert key before first entry >= key
      logic take;    // close the gap at take_idx
   } cell_cmd_type;

endpackage
`default_nettype wire

### sv/spt_cell.sv
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
`default_nettype none
module spt_cell import spt_pkg::*; #(
   parameter int PRIORITY_BITS = DEFAULT_PRIORITY_BITS,
   parameter int COUNT_BITS    = 5,
   parameter int CELL_INDEX    = 0
) (
   input  wire                     clock,
   input  wire cell_cmd_type       cmd,
   input  wire [PRIORITY_BITS-1:0] key_prio,
   input  wire [TAG_BITS-1:0]      key_tag,
   input  wire [COUNT_BITS-1:0]    take_idx,
   input  wire [COUNT_BITS-1:0]    count,
   input  wire                     left_at,
   input  wire [PRIORITY_BITS-1:0] left_prio,
   input  wire [TAG_BITS-1:0]      left_tag,
   input  wire [PRIORITY_BITS-1:0] right_prio,
   input  wire [TAG_BITS-1:0]      right_tag,
   output logic [PRIORITY_BITS-1:0] prio,
   output logic [TAG_BITS-1:0]      tag,
   output logic                     at_pos
);

   localparam logic [COUNT_BITS-1:0] MY_IDX = COUNT_BITS'(CELL_INDEX);

   logic [PRIORITY_BITS-1:0] prio_ff, prio_in;
   logic [TAG_BITS-1:0]      tag_ff, tag_in;

   // Insertion point lies at or before this slot (empty slots always qualify)
   assign at_pos = (MY_IDX >= count) || (prio_ff >= key_prio);

   // Next entry: load key at the boundary, shift up past it, or shift down on take
   always_comb begin
      prio_in = prio_ff;
      tag_in  = tag_ff;
      if (cmd.place && at_pos) begin
         if (!left_at) begin
            prio_in = key_prio;
            tag_in  = key_tag;
         end else begin
            prio_in = left_prio;
            tag_in  = left_tag;
         end
      end else if (cmd.take && (MY_IDX >= take_idx)) begin
         prio_in = right_prio;
         tag_in  = right_tag;
      end
   end

   always_ff @(posedge clock) begin
      prio_ff <= prio_in;
      tag_ff  <= tag_in;
   end

   assign prio = prio_ff;
   assign tag  = tag_ff;

endmodule
`default_nettype wire

### sv/sorted_priority_task_list_unit.sv
// Top level of the sorted priority task list: request sequencer and cell chain.
//
// Usage:
//   req_* channel: one beat per request (insert, delete at position, edit
//   priority at position). rsp_* channel: exactly one beat per request with
//   status, entry count after the request and the removed entry.
//   Entries sit in a chain of LIST_DEPTH cells kept in ascending priority;
//   every cell compares against the key and shifts with its neighbors in
//   the same cycle, so an insert or delete is one chain step.
//   Steps: insert, delete and rejected requests are done in the execute
//   step, which loads the response; edit does a take step, then a place
//   step. A new request is taken the cycle after the response is loaded,
//   so no request is taken before the response of the last one is loaded.
//   The response register holds its beat while rsp_ready is low; the
//   sequencer may already take the next request and waits at its final
//   step until the response register is free.
//   Reset (synchronous) empties the list and drops any pending response;
//   slot contents are not cleared since only held slots are ever read.
`default_nettype none
module sorted_priority_task_list_unit import spt_pkg::*; #(
   parameter int LIST_DEPTH    = DEFAULT_LIST_DEPTH,
   parameter int PRIORITY_BITS = DEFAULT_PRIORITY_BITS
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_ready,
   input  wire [1:0]                  req_type,
   input  wire [15:0]                 req_new_priority,
   input  wire [TAG_BITS-1:0]         req_entry_tag,
   input  wire [POS_BITS-1:0]         req_position,
   output logic                       rsp_valid,
   input  wire                        rsp_ready,
   output logic [1:0]                 rsp_status,
   output logic [OUT_CNT_BITS-1:0]    rsp_entry_count,
   output logic [OUT_PRIO_BITS-1:0]   rsp_removed_priority,
   output logic [TAG_BITS-1:0]        rsp_removed_tag
);

   localparam int CW = $clog2(LIST_DEPTH + 1);
   localparam int WW = (CW > POS_BITS) ? CW : POS_BITS;
   localparam logic [15:0] IN_MASK = (PRIORITY_BITS >= 16) ? 16'hFFFF :
                                     16'((32'd1 << PRIORITY_BITS) - 32'd1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(LIST_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_EXEC  = 3'b010,
      S_PLACE = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;

   // Captured request
   logic [1:0]               type_ff;
   logic [PRIORITY_BITS-1:0] prio_ff;
   logic [TAG_BITS-1:0]      tag_ff;
   logic [POS_BITS-1:0]      pos_ff;

   // Entry taken out by an edit, waiting to be placed again
   logic [PRIORITY_BITS-1:0] rem_prio_ff, rem_prio_in;
   logic [TAG_BITS-1:0]      rem_tag_ff, rem_tag_in;

   // Response register
   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic [CW-1:0]            rsp_count_ff, rsp_count_in;
   logic [PRIORITY_BITS-1:0] rsp_prio_ff, rsp_prio_in;
   logic [TAG_BITS-1:0]      rsp_tag_ff, rsp_tag_in;

   // Chain wiring
   cell_cmd_type             cmd;
   logic [TAG_BITS-1:0]      key_tag;
   logic [CW-1:0]            take_idx;
   logic [PRIORITY_BITS-1:0] cell_prio [LIST_DEPTH];
   logic [TAG_BITS-1:0]      cell_tag  [LIST_DEPTH];
   logic                     cell_at   [LIST_DEPTH];

   logic                     out_free;
   status_type               st;
   logic [PRIORITY_BITS-1:0] sel_prio;
   logic [TAG_BITS-1:0]      sel_tag;

   assign req_ready = (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign take_idx  = CW'(pos_ff) - CW'(1);

   // Status of the captured request against the current count
   always_comb begin
      st = ST_OK;
      case (type_ff) inside
         REQ_INSERT: begin
            if (count_ff == FULL_COUNT) st = ST_FULL;
         end
         REQ_DELETE, REQ_EDIT: begin
            if (count_ff == '0) begin
               st = ST_EMPTY;
            end else if ((pos_ff == '0) || (WW'(pos_ff) > WW'(count_ff))) begin
               st = ST_RANGE;
            end
         end
         default: st = ST_OK;
      endcase
   end

   // Read the entry at the requested position out of the chain
   always_comb begin
      sel_prio = '0;
      sel_tag  = '0;
      for (int i = 0; i < LIST_DEPTH; i++) begin
         if (take_idx == CW'(i)) begin
            sel_prio = sel_prio | cell_prio[i];
            sel_tag  = sel_tag  | cell_tag[i];
         end
      end
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      cmd           = '0;
      key_tag       = tag_ff;
      rem_prio_in   = rem_prio_ff;
      rem_tag_in    = rem_tag_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_tag_in    = rsp_tag_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            if ((type_ff == REQ_EDIT) && (st == ST_OK)) begin
               cmd.take    = 1'b1;
               count_in    = count_ff - CW'(1);
               rem_prio_in = sel_prio;
               rem_tag_in  = sel_tag;
               state_in    = S_PLACE;
            end else if (out_free) begin
               rsp_prio_in = '0;
               rsp_tag_in  = '0;
               if ((type_ff == REQ_INSERT) && (st == ST_OK)) begin
                  cmd.place = 1'b1;
                  count_in  = count_ff + CW'(1);
               end else if ((type_ff == REQ_DELETE) && (st == ST_OK)) begin
                  cmd.take    = 1'b1;
                  count_in    = count_ff - CW'(1);
                  rsp_prio_in = sel_prio;
                  rsp_tag_in  = sel_tag;
               end
               rsp_valid_in  = 1'b1;
               rsp_status_in = st;
               rsp_count_in  = count_in;
               state_in      = S_IDLE;
            end
         end
         S_PLACE: begin
            key_tag = rem_tag_ff;
            if (out_free) begin
               cmd.place     = 1'b1;
               count_in      = count_ff + CW'(1);
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_count_in  = count_in;
               rsp_prio_in   = rem_prio_ff;
               rsp_tag_in    = rem_tag_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         type_ff <= req_type;
         prio_ff <= PRIORITY_BITS'(req_new_priority & IN_MASK);
         tag_ff  <= req_entry_tag;
         pos_ff  <= req_position;
      end
      rem_prio_ff   <= rem_prio_in;
      rem_tag_ff    <= rem_tag_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_tag_ff    <= rsp_tag_in;
   end

   // Cell chain
   for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
      logic                     l_at;
      logic [PRIORITY_BITS-1:0] l_prio, r_prio;
      logic [TAG_BITS-1:0]      l_tag, r_tag;

      if (g == 0) begin : g_first
         assign l_at   = 1'b0;
         assign l_prio = '0;
         assign l_tag  = '0;
      end else begin : g_mid
         assign l_at   = cell_at[g-1];
         assign l_prio = cell_prio[g-1];
         assign l_tag  = cell_tag[g-1];
      end

      if (g == LIST_DEPTH - 1) begin : g_last
         assign r_prio = '0;
         assign r_tag  = '0;
      end else begin : g_body
         assign r_prio = cell_prio[g+1];
         assign r_tag  = cell_tag[g+1];
      end

      spt_cell #(
         .PRIORITY_BITS (PRIORITY_BITS),
         .COUNT_BITS    (CW),
         .CELL_INDEX    (g)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .key_prio   (prio_ff),
         .key_tag    (key_tag),
         .take_idx   (take_idx),
         .count      (count_ff),
         .left_at    (l_at),
         .left_prio  (l_prio),
         .left_tag   (l_tag),
         .right_prio (r_prio),
         .right_tag  (r_tag),
         .prio       (cell_prio[g]),
         .tag        (cell_tag[g]),
         .at_pos     (cell_at[g])
      );
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_entry_count      = OUT_CNT_BITS'(rsp_count_ff);
   assign rsp_removed_priority = OUT_PRIO_BITS'(rsp_prio_ff);
   assign rsp_removed_tag      = rsp_tag_ff;

endmodule
`default_nettype wire

### sv/spt_checker.sv
// Port-level checks for the sorted priority task list, bound to the top level.
`default_nettype none
module spt_checker import spt_pkg::*; #(
   parameter int LIST_DEPTH = DEFAULT_LIST_DEPTH
) (
   input wire                      clock,
   input wire                      reset,
   input wire                      req_valid,
   input wire                      req_ready,
   input wire                      rsp_valid,
   input wire                      rsp_ready,
   input wire [1:0]                rsp_status,
   input wire [OUT_CNT_BITS-1:0]   rsp_entry_count,
   input wire [OUT_PRIO_BITS-1:0]  rsp_removed_priority,
   input wire [TAG_BITS-1:0]       rsp_removed_tag
);

   // A stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_entry_count) && $stable(rsp_removed_priority) &&
      $stable(rsp_removed_tag))
      else $error("response beat changed while stalled");

   // One request at a time
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // Nothing removed unless the request succeeded
   a_no_removed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |->
      (rsp_removed_priority == '0) && (rsp_removed_tag == '0))
      else $error("removed entry on a rejected request");

   // Full reject reports a full list
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL) |->
      rsp_entry_count == OUT_CNT_BITS'(LIST_DEPTH))
      else $error("full status with count below depth");

   // Empty reject reports zero entries
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_EMPTY) |-> rsp_entry_count == '0)
      else $error("empty status with entries held");

endmodule

bind sorted_priority_task_list_unit spt_checker #(
   .LIST_DEPTH (LIST_DEPTH)
) u_spt_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_ready            (req_ready),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_status           (rsp_status),
   .rsp_entry_count      (rsp_entry_count),
   .rsp_removed_priority (rsp_removed_priority),
   .rsp_removed_tag      (rsp_removed_tag)
);
`default_nettype wire

### sim/tb.sv
// Self-checking testbench for the sorted priority task list unit.
`default_nettype none
module tb;
   import spt_pkg::*;

   localparam int LIST_DEPTH    = DEFAULT_LIST_DEPTH;
   localparam int PRIORITY_BITS = DEFAULT_PRIORITY_BITS;
   localparam int PHASE_ITEMS   = 412;
   localparam int HOLD_CYCLES   = 400;
   localparam int HEAVY_IDLE    = 58;
   localparam int LIGHT_IDLE    = 17;

   typedef enum int {PH_STEADY, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH_IDLE} phase_type;

   typedef struct {
      req_code_type        kind;
      logic [15:0]         prio;
      logic [TAG_BITS-1:0] tag;
      logic [POS_BITS-1:0] pos;
   } task_req_type;

   typedef struct {
      status_type               status;
      logic [OUT_CNT_BITS-1:0]  count;
      logic [OUT_PRIO_BITS-1:0] rem_prio;
      logic [TAG_BITS-1:0]      rem_tag;
   } task_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [1:0]               req_type = REQ_INSERT;
   logic [15:0]              req_new_priority = '0;
   logic [TAG_BITS-1:0]      req_entry_tag = '0;
   logic [POS_BITS-1:0]      req_position = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [1:0]               rsp_status;
   logic [OUT_CNT_BITS-1:0]  rsp_entry_count;
   logic [OUT_PRIO_BITS-1:0] rsp_removed_priority;
   logic [TAG_BITS-1:0]      rsp_removed_tag;

   // Shadow of the list contents
   logic [15:0]         list_prio [LIST_DEPTH];
   logic [TAG_BITS-1:0] list_tag  [LIST_DEPTH];
   int                  list_cnt = 0;

   task_req_type pend_q [$];
   task_rsp_type due_rsp_q [$];
   task_req_type cur_req;
   int        gen_cnt = 0;
   int        err_cnt = 0;
   int        tx_pct = 0;
   int        rx_pct = 0;
   logic      rsp_hold = 1'b0;
   logic      random_started = 1'b0;

   sorted_priority_task_list_unit #(
      .LIST_DEPTH    (LIST_DEPTH),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_type             (req_type),
      .req_new_priority     (req_new_priority),
      .req_entry_tag        (req_entry_tag),
      .req_position         (req_position),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_entry_count      (rsp_entry_count),
      .rsp_removed_priority (rsp_removed_priority),
      .rsp_removed_tag      (rsp_removed_tag)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Sorted insert: goes ahead of the first entry with priority >= new one
   function automatic void place_entry(logic [15:0] p, logic [TAG_BITS-1:0] t);
      int at;
      at = 0;
      while (at < list_cnt && list_prio[at] < p) at++;
      for (int i = list_cnt; i > at; i--) begin
         list_prio[i] = list_prio[i-1];
         list_tag[i]  = list_tag[i-1];
      end
      list_prio[at] = p;
      list_tag[at]  = t;
      list_cnt++;
   endfunction

   // Apply one request to the shadow list and return the response it gives
   function automatic task_rsp_type apply_request(task_req_type r);
      task_rsp_type o;
      int        idx;
      o.status   = ST_OK;
      o.rem_prio = '0;
      o.rem_tag  = '0;
      case (r.kind)
         REQ_INSERT: begin
            if (list_cnt >= LIST_DEPTH) o.status = ST_FULL;
            else place_entry(r.prio, r.tag);
         end
         REQ_DELETE, REQ_EDIT: begin
            if (list_cnt == 0) begin
               o.status = ST_EMPTY;
            end else if (r.pos == 0 || r.pos > list_cnt) begin
               o.status = ST_RANGE;
            end else begin
               idx        = r.pos - 1;
               o.rem_prio = list_prio[idx];
               o.rem_tag  = list_tag[idx];
               for (int i = idx; i + 1 < list_cnt; i++) begin
                  list_prio[i] = list_prio[i+1];
                  list_tag[i]  = list_tag[i+1];
               end
               list_cnt--;
               // edit keeps the tag, re-sorted under its new priority
               if (r.kind == REQ_EDIT) place_entry(r.prio, o.rem_tag);
            end
         end
         default: ;
      endcase
      o.count = list_cnt[OUT_CNT_BITS-1:0];
      return o;
   endfunction

   // Queue a request; gen_cnt follows the fill level for position choice
   task automatic push_req(req_code_type k, logic [15:0] p, logic [TAG_BITS-1:0] t,
                           logic [POS_BITS-1:0] pos);
      task_req_type r;
      r.kind = k;
      r.prio = p;
      r.tag  = t;
      r.pos  = pos;
      pend_q.push_back(r);
      if (k == REQ_INSERT && gen_cnt < LIST_DEPTH) gen_cnt++;
      else if (k == REQ_DELETE && gen_cnt > 0 && pos != 0 && pos <= gen_cnt) gen_cnt--;
   endtask

   // Request driver: takes beats from pend_q, random gaps per phase
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) due_rsp_q.push_back(apply_request(cur_req));
         if (!req_valid || req_ready) begin
            if (pend_q.size() != 0 && $urandom_range(0, 99) >= tx_pct) begin
               cur_req = pend_q.pop_front();
               req_valid        <= 1'b1;
               req_type         <= cur_req.kind;
               req_new_priority <= cur_req.prio;
               req_entry_tag    <= cur_req.tag;
               req_position     <= cur_req.pos;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: checks each beat against the oldest expectation
   always @(posedge clock) begin
      task_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_rsp_q.size() == 0) begin
               $display("%0t: unexpected response status %0d count %0d prio %h tag %h",
                        $time, rsp_status, rsp_entry_count, rsp_removed_priority,
                        rsp_removed_tag);
               err_cnt++;
            end else begin
               want = due_rsp_q.pop_front();
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d", $time, want.status,
                           rsp_status);
                  err_cnt++;
               end
               if (rsp_entry_count !== want.count) begin
                  $display("%0t: entry_count expected %0d actual %0d", $time, want.count,
                           rsp_entry_count);
                  err_cnt++;
               end
               if (rsp_removed_priority !== want.rem_prio) begin
                  $display("%0t: removed_priority expected %h actual %h", $time,
                           want.rem_prio, rsp_removed_priority);
                  err_cnt++;
               end
               if (rsp_removed_tag !== want.rem_tag) begin
                  $display("%0t: removed_tag expected %h actual %h", $time, want.rem_tag,
                           rsp_removed_tag);
                  err_cnt++;
               end
            end
         end
         rsp_ready <= !rsp_hold && ($urandom_range(0, 99) >= rx_pct);
      end
   end

   // Long receiver hold-off early in the random part, sender keeps offering
   initial begin
      wait (random_started);
      repeat (20) @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      #8000000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      int        roll;
      int        ins_pct;
      logic [15:0] p;
      logic [POS_BITS-1:0] pos;
      req_code_type k;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty list, fill to full, overflow, bad positions, edits
      push_req(REQ_DELETE, 16'h0000, 16'h0000, 5'd1);
      push_req(REQ_EDIT,   16'h1234, 16'h0000, 5'd1);
      push_req(REQ_NONE,   16'hFFFF, 16'hFFFF, 5'd31);
      push_req(REQ_INSERT, 16'h0000, 16'h0000, 5'd0);
      push_req(REQ_INSERT, 16'hFFFF, 16'hFFFF, 5'd0);
      push_req(REQ_INSERT, 16'h8000, 16'h0001, 5'd0);
      push_req(REQ_INSERT, 16'h8000, 16'h0002, 5'd0);  // equal key lands first
      push_req(REQ_INSERT, 16'h0001, 16'h0003, 5'd0);
      push_req(REQ_INSERT, 16'hFFFE, 16'h0004, 5'd0);
      for (int i = 0; i < 10; i++)
         push_req(REQ_INSERT, 16'h4000 + 16'(i * 'h0913), 16'h0100 + 16'(i), 5'd0);
      push_req(REQ_INSERT, 16'h5555, 16'hAAAA, 5'd0);  // list full
      push_req(REQ_DELETE, 16'h0000, 16'h0000, 5'd0);
      push_req(REQ_EDIT,   16'h2222, 16'h0000, 5'd17);
      push_req(REQ_DELETE, 16'h0000, 16'h0000, 5'd31);
      push_req(REQ_EDIT,   16'hFFFF, 16'h0000, 5'd1);
      push_req(REQ_EDIT,   16'h0000, 16'h0000, 5'd16);
      push_req(REQ_DELETE, 16'h0000, 16'h0000, 5'd16);
      push_req(REQ_DELETE, 16'h0000, 16'h0000, 5'd1);
      push_req(REQ_NONE,   16'h0000, 16'h0000, 5'd0);
      // sender waits here until every response is back
      while (pend_q.size() != 0 || req_valid || due_rsp_q.size() != 0) @(posedge clock);

      // Random phases, one per idling style
      random_started = 1'b1;
      ins_pct = 50;
      for (int ph = PH_STEADY; ph <= PH_BOTH_IDLE; ph++) begin
         case (phase_type'(ph))
            PH_STEADY:     begin tx_pct = 0;          rx_pct = 0;          end
            PH_SEND_IDLE:  begin tx_pct = HEAVY_IDLE; rx_pct = 0;          end
            PH_RECV_STALL: begin tx_pct = 0;          rx_pct = HEAVY_IDLE; end
            default:       begin tx_pct = LIGHT_IDLE; rx_pct = LIGHT_IDLE; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // each burst picks at random between filling, churning and draining
            if (n % 40 == 0) begin
               case ($urandom_range(0, 2))
                  0:       ins_pct = 85;
                  1:       ins_pct = 50;
                  default: ins_pct = 15;
               endcase
            end
            roll = $urandom_range(0, 99);
            if (roll < 3) k = REQ_NONE;
            else if (roll < 3 + ins_pct * 97 / 100) k = REQ_INSERT;
            else if ($urandom_range(0, 1) != 0) k = REQ_DELETE;
            else k = REQ_EDIT;
            // small keys give many ties, plus both extremes
            roll = $urandom_range(0, 99);
            if (roll < 45) p = 16'($urandom_range(0, 7));
            else if (roll < 52) p = 16'h0000;
            else if (roll < 59) p = 16'hFFFF;
            else p = 16'($urandom);
            if (gen_cnt == 0 || $urandom_range(0, 9) == 0) pos = 5'($urandom_range(0, 31));
            else pos = 5'($urandom_range(1, gen_cnt));
            push_req(k, p, 16'($urandom), pos);
         end
         while (pend_q.size() != 0 || req_valid || due_rsp_q.size() != 0) @(posedge clock);
      end

      repeat (10) @(posedge clock);
      if (err_cnt == 0 && due_rsp_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
`default_nettype wire

### sorted_priority_task_list_unit.f
sv/spt_pkg.sv
sv/spt_cell.sv
sv/sorted_priority_task_list_unit.sv
sv/spt_checker.sv
sim/tb.sv
